// ===== sv/i2cmbe_pkg.sv =====
`default_nettype none

package i2cmbe_pkg;

    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 4;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ      = 3'd3,
        CMD_SEND_ACK  = 3'd4,
        CMD_RECV_ACK  = 3'd5
    } cmd_t;

    typedef enum logic [4:0] {
        STEP_IDLE       = 5'd0,
        STEP_STA_SDA_HI = 5'd1,
        STEP_STA_SCL_HI = 5'd2,
        STEP_STA_SDA_LO = 5'd3,
        STEP_STA_SCL_LO = 5'd4,
        STEP_STO_SDA_LO = 5'd5,
        STEP_STO_SCL_HI = 5'd6,
        STEP_STO_SDA_HI = 5'd7,
        STEP_WR_SDA     = 5'd8,
        STEP_WR_SCL_HI  = 5'd9,
        STEP_WR_SCL_LO  = 5'd10,
        STEP_RA_SDA_HI  = 5'd11,
        STEP_RA_SCL_HI  = 5'd12,
        STEP_RA_SAMPLE  = 5'd13,
        STEP_RA_SCL_LO  = 5'd14,
        STEP_RD_SDA_HI  = 5'd15,
        STEP_RD_SCL_HI  = 5'd16,
        STEP_RD_SAMPLE  = 5'd17,
        STEP_RD_SCL_LO  = 5'd18,
        STEP_SA_SDA     = 5'd19,
        STEP_SA_SCL_HI  = 5'd20,
        STEP_SA_SCL_LO  = 5'd21,
        STEP_TAIL       = 5'd22
    } step_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd_byte;
        logic              ack_bit;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/i2c_master_byte_engine.sv =====
// I2C master byte engine, bit-banged open-drain, advanced by one tick per request.
// Input channel (in_valid/in_ready) carries one tick: cmd_valid, req_type,
// write_data, ack_to_send and the sampled sda_in. Each accepted tick yields
// exactly one result request on the output channel (out_valid/out_ready) with
// the line levels, busy, done, the last read byte and the last acknowledge.
// The sequencer state and next result are computed in the same cycle the tick is
// accepted and registered: one request per cycle while the results are taken.
// The hold count set by cfg_wr_en/cfg_wr_data is counted in ticks, not clocks.
// When the receiver stalls, the held result stays in the output register and
// in_ready drops until it is taken; no tick is lost and the bus state freezes.
// Reset leaves the sequencer's lines released, the engine idle, the hold count at
// two ticks and the output channel empty. The user must see that configuration
// is written only while idle; the block itself does not enforce it.
`default_nettype none

module i2c_master_byte_engine
    import i2cmbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [HOLD_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              cmd_valid,
    input  wire logic [2:0]        req_type,
    input  wire logic [BYTE_W-1:0] write_data,
    input  wire logic              ack_to_send,
    input  wire logic              sda_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [BYTE_W-1:0]      read_data,
    output logic                   ack_received
);

    res_t res_next;
    res_t res_q;
    logic tick;

    assign tick = in_valid && in_ready;

    i2cmbe_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (tick),
        .cmd_valid   (cmd_valid),
        .req_type    (req_type),
        .write_data  (write_data),
        .ack_to_send (ack_to_send),
        .sda_in      (sda_in),
        .res_next    (res_next)
    );

    i2cmbe_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_next  (res_next),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign scl_out      = res_q.scl;
    assign sda_out      = res_q.sda;
    assign busy_res     = res_q.busy;
    assign done_res     = res_q.done;
    assign read_data    = res_q.rd_byte;
    assign ack_received = res_q.ack_bit;

endmodule

`default_nettype wire

// ===== sv/i2cmbe_seq.sv =====
`default_nettype none

module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [HOLD_W-1:0] cfg_wr_data,
    input  wire logic              tick,
    input  wire logic              cmd_valid,
    input  wire logic [2:0]        req_type,
    input  wire logic [BYTE_W-1:0] write_data,
    input  wire logic              ack_to_send,
    input  wire logic              sda_in,
    output res_t                   res_next
);

    logic [HOLD_W-1:0]   hold_ticks_reg;
    step_t               step_reg, step_next;
    logic [BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_bit_reg, ack_bit_next;
    logic                ack_level_reg, ack_level_next;
    logic [BYTE_W-1:0]   rd_byte_reg, rd_byte_next;
    logic                done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            hold_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            bit_count_reg  <= '0;
            hold_count_reg <= '0;
            shift_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_bit_reg    <= 1'b0;
            ack_level_reg  <= 1'b0;
            rd_byte_reg    <= '0;
        end
        else if (tick)
        begin
            step_reg       <= step_next;
            bit_count_reg  <= bit_count_next;
            hold_count_reg <= hold_count_next;
            shift_reg      <= shift_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_bit_reg    <= ack_bit_next;
            ack_level_reg  <= ack_level_next;
            rd_byte_reg    <= rd_byte_next;
        end
    end

    // Next state: take a command when idle, then either count down the hold
    // or perform the operation of the current step.
    always_comb
    begin
        logic                accepted;
        step_t               step_v;
        logic [BITCNT_W-1:0] bc_v;
        accepted        = 1'b0;
        step_v          = step_reg;
        bc_v            = bit_count_reg;
        hold_count_next = hold_count_reg;
        shift_next      = shift_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_bit_next    = ack_bit_reg;
        ack_level_next  = ack_level_reg;
        rd_byte_next    = rd_byte_reg;
        done_next       = 1'b0;

        if (step_reg == STEP_IDLE && cmd_valid)
        begin
            accepted        = 1'b1;
            bc_v            = '0;
            hold_count_next = '0;
            unique case (req_type)
                CMD_START:
                begin
                    step_v = STEP_STA_SDA_HI;
                end
                CMD_STOP:
                begin
                    step_v = STEP_STO_SDA_LO;
                end
                CMD_WRITE:
                begin
                    step_v     = STEP_WR_SDA;
                    shift_next = write_data;
                end
                CMD_READ:
                begin
                    step_v     = STEP_RD_SDA_HI;
                    shift_next = '0;
                end
                CMD_SEND_ACK:
                begin
                    step_v         = STEP_SA_SDA;
                    ack_level_next = ack_to_send;
                end
                CMD_RECV_ACK:
                begin
                    step_v = STEP_RA_SDA_HI;
                end
                default:
                begin
                    accepted        = 1'b0;
                    bc_v            = bit_count_reg;
                    hold_count_next = hold_count_reg;
                end
            endcase
        end

        if (step_v != STEP_IDLE)
        begin
            if (hold_count_reg != '0 && !accepted)
            begin
                hold_count_next = hold_count_reg - 16'd1;
            end
            else
            begin
                hold_count_next = hold_ticks_reg;
                unique case (step_v)
                    STEP_STA_SDA_HI: begin sda_next = 1'b1; step_v = STEP_STA_SCL_HI; end
                    STEP_STA_SCL_HI: begin scl_next = 1'b1; step_v = STEP_STA_SDA_LO; end
                    STEP_STA_SDA_LO: begin sda_next = 1'b0; step_v = STEP_STA_SCL_LO; end
                    STEP_STA_SCL_LO: begin scl_next = 1'b0; step_v = STEP_TAIL; end
                    STEP_STO_SDA_LO: begin sda_next = 1'b0; step_v = STEP_STO_SCL_HI; end
                    STEP_STO_SCL_HI: begin scl_next = 1'b1; step_v = STEP_STO_SDA_HI; end
                    STEP_STO_SDA_HI: begin sda_next = 1'b1; step_v = STEP_TAIL; end
                    STEP_WR_SDA:
                    begin
                        sda_next = shift_next[3'd7 - bc_v[2:0]];
                        step_v   = STEP_WR_SCL_HI;
                    end
                    STEP_WR_SCL_HI: begin scl_next = 1'b1; step_v = STEP_WR_SCL_LO; end
                    STEP_WR_SCL_LO:
                    begin
                        scl_next = 1'b0;
                        bc_v     = bc_v + 4'd1;
                        step_v   = bc_v[3] ? STEP_RA_SDA_HI : STEP_WR_SDA;
                    end
                    STEP_RA_SDA_HI: begin sda_next = 1'b1; step_v = STEP_RA_SCL_HI; end
                    STEP_RA_SCL_HI: begin scl_next = 1'b1; step_v = STEP_RA_SAMPLE; end
                    STEP_RA_SAMPLE: begin ack_bit_next = sda_in; step_v = STEP_RA_SCL_LO; end
                    STEP_RA_SCL_LO: begin scl_next = 1'b0; step_v = STEP_TAIL; end
                    STEP_RD_SDA_HI: begin sda_next = 1'b1; step_v = STEP_RD_SCL_HI; end
                    STEP_RD_SCL_HI: begin scl_next = 1'b1; step_v = STEP_RD_SAMPLE; end
                    STEP_RD_SAMPLE:
                    begin
                        shift_next = {shift_next[BYTE_W-2:0], sda_in};
                        step_v     = STEP_RD_SCL_LO;
                    end
                    STEP_RD_SCL_LO:
                    begin
                        scl_next = 1'b0;
                        bc_v     = bc_v + 4'd1;
                        if (bc_v[3])
                        begin
                            rd_byte_next = shift_next;
                            step_v       = STEP_TAIL;
                        end
                        else
                        begin
                            step_v = STEP_RD_SCL_HI;
                        end
                    end
                    STEP_SA_SDA:
                    begin
                        sda_next = ~ack_level_next;
                        step_v   = STEP_SA_SCL_HI;
                    end
                    STEP_SA_SCL_HI: begin scl_next = 1'b1; step_v = STEP_SA_SCL_LO; end
                    STEP_SA_SCL_LO: begin scl_next = 1'b0; step_v = STEP_TAIL; end
                    default:        begin step_v = STEP_TAIL; end
                endcase
            end
            if (hold_count_next == '0 && step_v == STEP_TAIL)
            begin
                step_v    = STEP_IDLE;
                done_next = 1'b1;
            end
        end

        step_next      = step_v;
        bit_count_next = bc_v;
    end

    always_comb
    begin
        res_next.scl     = scl_next;
        res_next.sda     = sda_next;
        res_next.busy    = (step_next != STEP_IDLE);
        res_next.done    = done_next;
        res_next.rd_byte = rd_byte_next;
        res_next.ack_bit = ack_bit_next;
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick |-> !(res_next.done && res_next.busy))
        else $error("done and busy reported together");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_IDLE |-> hold_count_reg == '0)
        else $error("hold count left over while idle");

    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_TAIL |-> hold_count_reg != '0)
        else $error("tail step reached with no hold pending");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit count beyond one byte");

endmodule

`default_nettype wire

// ===== sv/i2cmbe_out.sv =====
`default_nettype none

module i2cmbe_out
    import i2cmbe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire res_t res_next,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      res_q
);

    logic out_valid_reg, out_valid_next;
    res_t res_reg;
    logic load;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_q     = res_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import i2cmbe_pkg::*;

    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int GAP_PCT = 38;
    localparam int BUSY_NOISE_PCT = 30;
    localparam int SDA_LOW = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RANDOM = 2;

    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        req;
        logic [BYTE_W-1:0] wdata;
        logic              ack;
        logic              sda;
    } tick_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [HOLD_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    tick_t             tick_q = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_received;

    tick_t ticks_to_send[$];
    res_t  outputs_due[$];
    int    mismatches = 0;
    int    stall_cycles = 0;
    int    ticks_queued = 0;
    bit    no_gaps = 1'b0;

    // Shadow copy of the sequencer and its hold setting.
    step_t               seq_phase = STEP_IDLE;
    logic [BITCNT_W-1:0] bits_done = '0;
    logic [HOLD_W-1:0]   hold_left = '0;
    logic [HOLD_W-1:0]   hold_cfg = HOLD_RESET;
    logic [BYTE_W-1:0]   shreg = '0;
    logic [BYTE_W-1:0]   rx_byte = '0;
    logic                scl_lvl = 1'b1;
    logic                sda_lvl = 1'b1;
    logic                last_ack = 1'b0;
    logic                ack_drive = 1'b0;

    i2c_master_byte_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd_valid    (tick_q.cmd_valid),
        .req_type     (tick_q.req),
        .write_data   (tick_q.wdata),
        .ack_to_send  (tick_q.ack),
        .sda_in       (tick_q.sda),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_received (ack_received)
    );

    always #6 clk = ~clk;

    task automatic compute_bus_outputs(input tick_t t);
        logic  started;
        res_t  want;
        step_t nxt;
        started = 1'b0;
        want = '0;
        if (seq_phase == STEP_IDLE && t.cmd_valid && t.req <= CMD_RECV_ACK)
        begin
            case (t.req)
                CMD_START:    seq_phase = STEP_STA_SDA_HI;
                CMD_STOP:     seq_phase = STEP_STO_SDA_LO;
                CMD_WRITE:    seq_phase = STEP_WR_SDA;
                CMD_READ:     seq_phase = STEP_RD_SDA_HI;
                CMD_SEND_ACK: seq_phase = STEP_SA_SDA;
                default:      seq_phase = STEP_RA_SDA_HI;
            endcase
            bits_done = '0;
            hold_left = '0;
            if (t.req == CMD_WRITE)
                shreg = t.wdata;
            if (t.req == CMD_READ)
                shreg = '0;
            if (t.req == CMD_SEND_ACK)
                ack_drive = t.ack;
            started = 1'b1;
        end
        if (seq_phase != STEP_IDLE)
        begin
            if (hold_left != '0 && !started)
            begin
                hold_left = hold_left - 16'd1;
            end
            else
            begin
                nxt = step_t'(seq_phase + 5'd1);
                case (seq_phase) inside
                    STEP_STA_SDA_HI, STEP_RA_SDA_HI, STEP_RD_SDA_HI:
                        sda_lvl = 1'b1;
                    STEP_STA_SCL_HI, STEP_STO_SCL_HI, STEP_WR_SCL_HI, STEP_RA_SCL_HI,
                    STEP_RD_SCL_HI, STEP_SA_SCL_HI:
                        scl_lvl = 1'b1;
                    STEP_STA_SDA_LO, STEP_STO_SDA_LO:
                        sda_lvl = 1'b0;
                    STEP_STA_SCL_LO, STEP_RA_SCL_LO, STEP_SA_SCL_LO:
                    begin
                        scl_lvl = 1'b0;
                        nxt = STEP_TAIL;
                    end
                    STEP_STO_SDA_HI:
                    begin
                        sda_lvl = 1'b1;
                        nxt = STEP_TAIL;
                    end
                    STEP_WR_SDA:
                        sda_lvl = shreg[3'd7 - bits_done[2:0]];
                    STEP_WR_SCL_LO:
                    begin
                        scl_lvl = 1'b0;
                        bits_done = bits_done + 4'd1;
                        nxt = bits_done[3] ? STEP_RA_SDA_HI : STEP_WR_SDA;
                    end
                    STEP_RA_SAMPLE:
                        last_ack = t.sda;
                    STEP_RD_SAMPLE:
                        shreg = {shreg[BYTE_W-2:0], t.sda};
                    STEP_RD_SCL_LO:
                    begin
                        scl_lvl = 1'b0;
                        bits_done = bits_done + 4'd1;
                        if (bits_done[3])
                        begin
                            rx_byte = shreg;
                            nxt = STEP_TAIL;
                        end
                        else
                            nxt = STEP_RD_SCL_HI;
                    end
                    STEP_SA_SDA:
                        sda_lvl = !ack_drive;
                    default:
                        nxt = STEP_TAIL;
                endcase
                seq_phase = nxt;
                hold_left = hold_cfg;
            end
            if (hold_left == '0 && seq_phase == STEP_TAIL)
            begin
                seq_phase = STEP_IDLE;
                want.done = 1'b1;
            end
        end
        want.scl = scl_lvl;
        want.sda = sda_lvl;
        want.busy = (seq_phase != STEP_IDLE);
        want.rd_byte = rx_byte;
        want.ack_bit = last_ack;
        outputs_due.push_back(want);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic check_outputs;
        res_t want;
        if (outputs_due.size() == 0)
        begin
            report_mismatch("result arrived with none outstanding");
        end
        else
        begin
            want = outputs_due.pop_front();
            compare_field("scl_out", {7'd0, scl_out}, {7'd0, want.scl});
            compare_field("sda_out", {7'd0, sda_out}, {7'd0, want.sda});
            compare_field("busy_res", {7'd0, busy_res}, {7'd0, want.busy});
            compare_field("done_res", {7'd0, done_res}, {7'd0, want.done});
            compare_field("read_data", read_data, want.rd_byte);
            compare_field("ack_received", {7'd0, ack_received}, {7'd0, want.ack_bit});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tick_q <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                compute_bus_outputs(tick_q);
            if (!in_valid || in_ready)
            begin
                if (ticks_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT))
                begin
                    in_valid <= 1'b1;
                    tick_q <= ticks_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_outputs();
            out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_tick(input logic v, input logic [2:0] r, input logic [7:0] d,
                              input logic a, input int sda_mode);
        tick_t t;
        t.cmd_valid = v;
        t.req = r;
        t.wdata = d;
        t.ack = a;
        case (sda_mode)
            SDA_LOW:  t.sda = 1'b0;
            SDA_HIGH: t.sda = 1'b1;
            default:  t.sda = 1'($urandom_range(1));
        endcase
        ticks_to_send.push_back(t);
        ticks_queued++;
    endtask

    task automatic queue_busy_noise(input int sda_mode);
        queue_tick($urandom_range(99) < BUSY_NOISE_PCT, 3'($urandom_range(7)),
                   8'($urandom_range(255)), 1'($urandom_range(1)), sda_mode);
    endtask

    task automatic queue_idle_tick;
        queue_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), SDA_RANDOM);
    endtask

    // A command tick followed by exactly enough ticks for it to finish, so the
    // next command lands on the first idle tick.
    task automatic queue_command(input logic [2:0] r, input logic [7:0] d, input logic a,
                                 input int sda_mode);
        int ops;
        int span;
        int i;
        case (r)
            CMD_START:    ops = 4;
            CMD_STOP:     ops = 3;
            CMD_WRITE:    ops = 28;
            CMD_READ:     ops = 25;
            CMD_SEND_ACK: ops = 3;
            CMD_RECV_ACK: ops = 4;
            default:      ops = 0;
        endcase
        span = (ops == 0) ? 1 : ops * (int'(hold_cfg) + 1);
        queue_tick(1'b1, r, d, a, sda_mode);
        for (i = 1; i < span; i++)
            queue_busy_noise(sda_mode);
    endtask

    task automatic run_random(input int n_ticks);
        int         stop_at;
        logic [2:0] r;
        stop_at = ticks_queued + n_ticks;
        while (ticks_queued < stop_at)
        begin
            if ($urandom_range(99) < 5)
                r = ($urandom_range(1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
            else
                r = 3'($urandom_range(5));
            queue_command(r, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RANDOM);
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) queue_idle_tick();
        end
    endtask

    task automatic wait_quiet;
        while (ticks_to_send.size() != 0 || outputs_due.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic set_hold(input logic [HOLD_W-1:0] v);
        wait_quiet();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        hold_cfg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        queue_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW);
        queue_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH);
        queue_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
        queue_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
        queue_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW);
        queue_command(CMD_SEND_ACK, 8'h00, 1'b1, SDA_RANDOM);
        queue_command(CMD_SEND_ACK, 8'h00, 1'b0, SDA_RANDOM);
        queue_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_LOW);
        queue_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_HIGH);
        queue_command(REQ_SPARE_LO, 8'h00, 1'b0, SDA_RANDOM);
        queue_command(REQ_SPARE_HI, 8'hFF, 1'b1, SDA_RANDOM);
        queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

        set_hold(16'd0);
        queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        queue_command(CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM);
        queue_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
        queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
        run_random(70);

        set_hold(16'd1);
        run_random(70);

        set_hold(16'd4);
        run_random(60);

        set_hold(16'd40);
        no_gaps = 1'b1;
        queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
        wait_quiet();

        set_hold(16'd3);
        queue_command(CMD_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RANDOM);
        wait_quiet();
        no_gaps = 1'b0;
        repeat (4) @(negedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/i2cmbe_pkg.sv
sv/i2cmbe_seq.sv
sv/i2cmbe_out.sv
sv/i2c_master_byte_engine.sv
tb/testbench.sv
